/* design/bli_pkg.sv */
// Shared types, constants and controller/datapath interface for the breakpoint interpolator.
package bli_pkg;

    // Table geometry
    localparam int MAX_POINTS = 256;
    localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    // Field widths
    localparam int WORD_W = 32;
    localparam int IDX_W  = 8;
    localparam int CNT_W  = 9;
    localparam int SEG_W  = 8;

    // Width that holds both the count register and the table depth
    localparam int WIDE_W = (CNT_W > ADDR_W + 1) ? CNT_W : ADDR_W + 1;

    // Divider step counter
    localparam int DIV_CNT_W = $clog2(WORD_W);

    typedef logic [WORD_W-1:0]   word_t;
    typedef logic [2*WORD_W-1:0] dword_t;
    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [SEG_W-1:0]    seg_t;
    typedef logic [WIDE_W-1:0]   wide_t;
    typedef logic [DIV_CNT_W-1:0] dcnt_t;

    // Request codes
    typedef enum logic [0:0] {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } req_t;

    // Table read address select
    typedef enum logic [2:0] {
        ADDR_ZERO,
        ADDR_LAST,
        ADDR_P,
        ADDR_P_INC,
        ADDR_P_DEC
    } addr_sel_t;

    // Cursor walk update
    typedef enum logic [1:0] {
        P_HOLD,
        P_INC,
        P_DEC
    } p_op_t;

    // Result register update
    typedef enum logic [2:0] {
        RES_HOLD,
        RES_FIRST,
        RES_LAST,
        RES_HI,
        RES_SUM
    } res_op_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic      start;
        logic      load;
        addr_sel_t addr_sel;
        p_op_t     p_op;
        logic      lat_hi;
        logic      lat_lo;
        logic      calc;
        logic      mul;
        logic      div_step;
        res_op_t   res_op;
        logic      out_load;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic q_le_t;
        logic q_ge_t;
        logic p_lt_last;
        logic p_zero;
        logic degen;
        logic out_free;
    } dp_stat_t;

endpackage

/* design/bli_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/bli_ctrl.sv */
// Controller state machine: sequences the table search, multiply and divide steps.
module bli_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_req_type,
    output logic               s_ready,
    input  bli_pkg::dp_stat_t  stat,
    output bli_pkg::dp_cmd_t   cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_PROBE,
        ST_FWD,
        ST_BWD,
        ST_GET_HI,
        ST_GET_LO,
        ST_CALC,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } state_t;

    state_t         state_reg, state_next;
    bli_pkg::dcnt_t div_cnt_reg, div_cnt_next;

    assign s_ready = (state_reg == ST_IDLE);

    // Next state and datapath commands
    always_comb begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        cmd.addr_sel = bli_pkg::ADDR_P;
        cmd.p_op     = bli_pkg::P_HOLD;
        cmd.res_op   = bli_pkg::RES_HOLD;
        unique case (state_reg)
            ST_IDLE: begin
                // read slot 0 so its time is ready for the low clamp test
                cmd.addr_sel = bli_pkg::ADDR_ZERO;
                if (s_valid) begin
                    if (s_req_type == bli_pkg::REQ_QUERY) begin
                        cmd.start  = 1'b1;
                        state_next = ST_FIRST;
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_FIRST: begin
                cmd.addr_sel = bli_pkg::ADDR_LAST;
                if (stat.q_le_t) begin
                    cmd.res_op = bli_pkg::RES_FIRST;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST: begin
                cmd.addr_sel = bli_pkg::ADDR_P;
                if (stat.q_ge_t) begin
                    cmd.res_op = bli_pkg::RES_LAST;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                // choose walk direction from the time at the cursor
                if (!stat.q_le_t) begin
                    if (stat.p_lt_last) begin
                        cmd.p_op     = bli_pkg::P_INC;
                        cmd.addr_sel = bli_pkg::ADDR_P_INC;
                        state_next   = ST_FWD;
                    end else begin
                        cmd.addr_sel = bli_pkg::ADDR_P;
                        state_next   = ST_GET_HI;
                    end
                end else if (!stat.p_zero) begin
                    cmd.p_op     = bli_pkg::P_DEC;
                    cmd.addr_sel = bli_pkg::ADDR_P_DEC;
                    state_next   = ST_BWD;
                end else begin
                    cmd.p_op     = bli_pkg::P_INC;
                    cmd.addr_sel = bli_pkg::ADDR_P_INC;
                    state_next   = ST_GET_HI;
                end
            end
            ST_FWD: begin
                if (stat.p_lt_last && !stat.q_le_t) begin
                    cmd.p_op     = bli_pkg::P_INC;
                    cmd.addr_sel = bli_pkg::ADDR_P_INC;
                end else begin
                    cmd.addr_sel = bli_pkg::ADDR_P;
                    state_next   = ST_GET_HI;
                end
            end
            ST_BWD: begin
                if (!stat.p_zero && stat.q_le_t) begin
                    cmd.p_op     = bli_pkg::P_DEC;
                    cmd.addr_sel = bli_pkg::ADDR_P_DEC;
                end else begin
                    // step back up onto the upper breakpoint
                    cmd.p_op     = bli_pkg::P_INC;
                    cmd.addr_sel = bli_pkg::ADDR_P_INC;
                    state_next   = ST_GET_HI;
                end
            end
            ST_GET_HI: begin
                cmd.lat_hi   = 1'b1;
                cmd.addr_sel = bli_pkg::ADDR_P_DEC;
                state_next   = ST_GET_LO;
            end
            ST_GET_LO: begin
                cmd.lat_lo = 1'b1;
                state_next = ST_CALC;
            end
            ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                if (stat.degen) begin
                    cmd.res_op = bli_pkg::RES_HI;
                    state_next = ST_OUT;
                end else begin
                    cmd.mul      = 1'b1;
                    div_cnt_next = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == bli_pkg::dcnt_t'(bli_pkg::WORD_W - 1)) begin
                    state_next = ST_FIN;
                end else begin
                    div_cnt_next = div_cnt_reg + 1'b1;
                end
            end
            ST_FIN: begin
                cmd.res_op = bli_pkg::RES_SUM;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

endmodule

/* design/bli_dp.sv */
// Datapath: breakpoint tables, cursor, multiplier, restoring divider and result registers.
module bli_dp (
    input  logic               aclk,
    input  logic               aresetn,
    input  bli_pkg::dp_cmd_t   cmd,
    output bli_pkg::dp_stat_t  stat,
    input  logic               cfg_wr_en,
    input  bli_pkg::cnt_t      cfg_wr_data,
    input  bli_pkg::idx_t      s_point_index,
    input  bli_pkg::word_t     s_point_time,
    input  bli_pkg::word_t     s_point_value,
    input  bli_pkg::word_t     s_query_time,
    output logic               m_valid,
    input  logic               m_ready,
    output bli_pkg::word_t     m_interp_value,
    output bli_pkg::seg_t      m_segment_end
);

    // Control state
    bli_pkg::cnt_t  count_reg;
    bli_pkg::addr_t cursor_reg;
    logic           m_valid_reg;

    // Search and arithmetic registers
    bli_pkg::word_t q_reg;
    bli_pkg::addr_t last_reg;
    bli_pkg::addr_t p_reg;
    bli_pkg::word_t t_hi_reg, v_hi_reg, t_lo_reg, v_lo_reg;
    bli_pkg::word_t dt_reg, span_reg, mag_reg;
    logic           neg_reg, degen_reg;
    bli_pkg::word_t rem_reg, quo_reg;
    bli_pkg::word_t res_val_reg;
    bli_pkg::addr_t res_seg_reg;
    bli_pkg::word_t m_val_reg;
    bli_pkg::seg_t  m_seg_reg;

    bli_pkg::wide_t cnt_wide, eff_count;
    bli_pkg::addr_t last_cur, p_start;
    bli_pkg::addr_t raddr, waddr;
    logic           tab_we;
    bli_pkg::word_t rd_t, rd_v;

    bli_pkg::word_t           dt_c, span_c, mag_c;
    logic [bli_pkg::WORD_W:0] dv_up, dv_dn;
    bli_pkg::dword_t          prod;
    logic [bli_pkg::WORD_W:0] trial;
    logic                     trial_ge;
    bli_pkg::word_t           rem_step;
    bli_pkg::word_t           res_sum;

    // Effective count clamped to 2..MAX_POINTS, last slot and starting cursor
    always_comb begin
        cnt_wide = bli_pkg::wide_t'(count_reg);
        if (cnt_wide < bli_pkg::wide_t'(2)) begin
            eff_count = bli_pkg::wide_t'(2);
        end else if (cnt_wide > bli_pkg::wide_t'(bli_pkg::MAX_POINTS)) begin
            eff_count = bli_pkg::wide_t'(bli_pkg::MAX_POINTS);
        end else begin
            eff_count = cnt_wide;
        end
        last_cur = bli_pkg::addr_t'(eff_count - bli_pkg::wide_t'(1));
        p_start  = (cursor_reg > last_cur) ? last_cur : cursor_reg;
    end

    // Table write on a load word; slots past the table are dropped
    assign tab_we = cmd.load &&
                    (bli_pkg::wide_t'(s_point_index) < bli_pkg::wide_t'(bli_pkg::MAX_POINTS));
    assign waddr  = bli_pkg::addr_t'(s_point_index);

    // Read address select
    always_comb begin
        unique case (cmd.addr_sel)
            bli_pkg::ADDR_ZERO:  raddr = '0;
            bli_pkg::ADDR_LAST:  raddr = last_reg;
            bli_pkg::ADDR_P:     raddr = p_reg;
            bli_pkg::ADDR_P_INC: raddr = p_reg + 1'b1;
            bli_pkg::ADDR_P_DEC: raddr = p_reg - 1'b1;
            default:             raddr = p_reg;
        endcase
    end

    bli_ram #(
        .WIDTH (bli_pkg::WORD_W),
        .DEPTH (bli_pkg::MAX_POINTS)
    ) u_time_ram (
        .aclk  (aclk),
        .we    (tab_we),
        .waddr (waddr),
        .wdata (s_point_time),
        .raddr (raddr),
        .rdata (rd_t)
    );

    bli_ram #(
        .WIDTH (bli_pkg::WORD_W),
        .DEPTH (bli_pkg::MAX_POINTS)
    ) u_value_ram (
        .aclk  (aclk),
        .we    (tab_we),
        .waddr (waddr),
        .wdata (s_point_value),
        .raddr (raddr),
        .rdata (rd_v)
    );

    // Segment deltas: elapsed time, span and value step magnitude
    always_comb begin
        dt_c   = q_reg - t_lo_reg;
        span_c = t_hi_reg - t_lo_reg;
        dv_up  = {v_hi_reg[bli_pkg::WORD_W-1], v_hi_reg} -
                 {v_lo_reg[bli_pkg::WORD_W-1], v_lo_reg};
        dv_dn  = {v_lo_reg[bli_pkg::WORD_W-1], v_lo_reg} -
                 {v_hi_reg[bli_pkg::WORD_W-1], v_hi_reg};
        mag_c  = dv_up[bli_pkg::WORD_W] ? dv_dn[bli_pkg::WORD_W-1:0]
                                        : dv_up[bli_pkg::WORD_W-1:0];
    end

    assign prod = bli_pkg::dword_t'(mag_reg) * bli_pkg::dword_t'(dt_reg);

    // One restoring divide step; remainder stays below the span
    always_comb begin
        trial    = {rem_reg, quo_reg[bli_pkg::WORD_W-1]};
        trial_ge = (trial >= {1'b0, span_reg});
        rem_step = trial_ge ? bli_pkg::word_t'(trial - {1'b0, span_reg})
                            : trial[bli_pkg::WORD_W-1:0];
    end

    assign res_sum = neg_reg ? (v_lo_reg - quo_reg) : (v_lo_reg + quo_reg);

    // Count register, cursor and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= bli_pkg::cnt_t'(2);
            cursor_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                count_reg <= cfg_wr_data;
            end
            if (cfg_wr_en || cmd.load) begin
                cursor_reg <= '0;
            end else if (cmd.lat_lo) begin
                cursor_reg <= p_reg;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Search registers
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            q_reg    <= s_query_time;
            last_reg <= last_cur;
            p_reg    <= p_start;
        end else begin
            unique case (cmd.p_op)
                bli_pkg::P_HOLD: p_reg <= p_reg;
                bli_pkg::P_INC:  p_reg <= p_reg + 1'b1;
                bli_pkg::P_DEC:  p_reg <= p_reg - 1'b1;
                default:         p_reg <= p_reg;
            endcase
        end
        if (cmd.lat_hi) begin
            t_hi_reg <= rd_t;
            v_hi_reg <= rd_v;
        end
        if (cmd.lat_lo) begin
            t_lo_reg <= rd_t;
            v_lo_reg <= rd_v;
        end
    end

    // Arithmetic registers
    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            dt_reg    <= dt_c;
            span_reg  <= span_c;
            mag_reg   <= mag_c;
            neg_reg   <= dv_up[bli_pkg::WORD_W];
            degen_reg <= (dt_c >= span_c);
        end
        if (cmd.mul) begin
            rem_reg <= prod[2*bli_pkg::WORD_W-1:bli_pkg::WORD_W];
            quo_reg <= prod[bli_pkg::WORD_W-1:0];
        end else if (cmd.div_step) begin
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[bli_pkg::WORD_W-2:0], trial_ge};
        end
    end

    // Result and output registers
    always_ff @(posedge aclk) begin
        if (cmd.lat_hi) begin
            res_seg_reg <= p_reg;
        end
        unique case (cmd.res_op)
            bli_pkg::RES_HOLD: begin
                res_val_reg <= res_val_reg;
            end
            bli_pkg::RES_FIRST: begin
                res_val_reg <= rd_v;
                res_seg_reg <= '0;
            end
            bli_pkg::RES_LAST: begin
                res_val_reg <= rd_v;
                res_seg_reg <= last_reg;
            end
            bli_pkg::RES_HI: begin
                res_val_reg <= v_hi_reg;
            end
            bli_pkg::RES_SUM: begin
                res_val_reg <= res_sum;
            end
            default: begin
                res_val_reg <= res_val_reg;
            end
        endcase
        if (cmd.out_load) begin
            m_val_reg <= res_val_reg;
            m_seg_reg <= bli_pkg::seg_t'(res_seg_reg);
        end
    end

    // Status to controller
    always_comb begin
        stat.q_le_t    = (q_reg <= rd_t);
        stat.q_ge_t    = (q_reg >= rd_t);
        stat.p_lt_last = (p_reg < last_reg);
        stat.p_zero    = (p_reg == '0);
        stat.degen     = degen_reg;
        stat.out_free  = !m_valid_reg || m_ready;
    end

    assign m_valid        = m_valid_reg;
    assign m_interp_value = m_val_reg;
    assign m_segment_end  = m_seg_reg;

endmodule

/* design/breakpoint_linear_interpolator.sv */
// Top level of the breakpoint linear interpolator: controller plus datapath.
//
//  channel   handshake          payload
//  -------   ----------------   ---------------------------------------------------
//  s_        s_valid/s_ready    req_type, point_index, point_time, point_value, query_time
//  m_        m_valid/m_ready    interp_value, segment_end
//  cfg_      cfg_wr_en          cfg_wr_data (point_count)
//
//  A query at or below the first time, or at or above the last time, is clamped to that
//  breakpoint's value; inside the table the cursor is stepped one slot at a time with one
//  table read per step (a backward walk ends with one step back up), and the result comes
//  from a multiply and a bit-serial divider. A degenerate segment (zero span, or elapsed
//  time not below the span) skips multiply and divide.
//  aresetn is synchronous, active low; it clears the FSM, the cursor and point_count to 2.
//  A stalled m_ side holds the finished word in the output register; a new word is
//  accepted meanwhile, and a query result waits only if the register is still full.
module breakpoint_linear_interpolator (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [bli_pkg::CNT_W-1:0]          cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_req_type,
    input  logic [bli_pkg::IDX_W-1:0]          s_point_index,
    input  logic [bli_pkg::WORD_W-1:0]         s_point_time,
    input  logic signed [bli_pkg::WORD_W-1:0]  s_point_value,
    input  logic [bli_pkg::WORD_W-1:0]         s_query_time,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [bli_pkg::WORD_W-1:0]  m_interp_value,
    output logic [bli_pkg::SEG_W-1:0]          m_segment_end
);

    bli_pkg::dp_cmd_t  cmd;
    bli_pkg::dp_stat_t stat;
    bli_pkg::word_t    value_out;

    bli_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_req_type),
        .s_ready    (s_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    bli_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_point_index  (s_point_index),
        .s_point_time   (s_point_time),
        .s_point_value  (bli_pkg::word_t'(s_point_value)),
        .s_query_time   (s_query_time),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_interp_value (value_out),
        .m_segment_end  (m_segment_end)
    );

    assign m_interp_value = $signed(value_out);

endmodule

/* tb/sv/breakpoint_linear_interpolator_tb.sv */
// Self-checking testbench for the breakpoint interpolator: table loads, queries, count changes.
module breakpoint_linear_interpolator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bli_pkg::*;

    localparam int RESET_CYCLES = 11;
    localparam int TARGET_WORDS = 1900;
    localparam int LOAD_SETTLE  = 4;
    localparam int DRAIN_CYCLES = 350;
    localparam int HOLD_CYCLES  = 500;
    localparam int CYCLE_LIMIT  = 4_000_000;

    typedef struct packed {
        word_t value;
        seg_t  seg;
    } interp_result_t;

    // Curve predictor plus the queue of results still owed by the block
    class interp_scoreboard;
        word_t          time_tbl[MAX_POINTS];
        word_t          value_tbl[MAX_POINTS];
        int             cursor;
        cnt_t           count_reg;
        interp_result_t pending[$];
        int             errors;

        function new();
            cursor    = 0;
            count_reg = 2;
            errors    = 0;
        endfunction

        function void set_count(cnt_t c);
            count_reg = c;
            cursor    = 0;
        endfunction

        // Value on segment lo..hi at time q, quotient truncated toward zero
        function word_t segment_value(word_t q, int lo, int hi);
            longint    v_lo, v_hi, rise;
            word_t     elapsed, span;
            bit [63:0] mag, quot;
            v_lo    = $signed(value_tbl[lo]);
            v_hi    = $signed(value_tbl[hi]);
            elapsed = q - time_tbl[lo];
            span    = time_tbl[hi] - time_tbl[lo];
            if (span == 0 || elapsed >= span)
                return word_t'(v_hi);
            rise = v_hi - v_lo;
            mag  = (rise < 0) ? -rise : rise;
            quot = (mag * 64'(elapsed)) / 64'(span);
            if (rise < 0)
                return word_t'(v_lo - longint'(quot));
            return word_t'(v_lo + longint'(quot));
        endfunction

        // Accepted input word: update the table or queue the predicted result
        function void note_word(req_t req, idx_t idx, word_t t, word_t v, word_t q);
            interp_result_t res;
            int             n, last_slot, p;
            if (req == REQ_LOAD) begin
                if (idx < MAX_POINTS) begin
                    time_tbl[idx]  = t;
                    value_tbl[idx] = v;
                end
                cursor = 0;
                return;
            end
            n = (count_reg < 2) ? 2 : ((count_reg > MAX_POINTS) ? MAX_POINTS : count_reg);
            last_slot = n - 1;
            if (q <= time_tbl[0]) begin
                res.value = value_tbl[0];
                res.seg   = '0;
            end else if (q >= time_tbl[last_slot]) begin
                res.value = value_tbl[last_slot];
                res.seg   = seg_t'(last_slot);
            end else begin
                // walk the cursor to the bracketing segment
                p = (cursor > last_slot) ? last_slot : cursor;
                if (q > time_tbl[p]) begin
                    while (p < last_slot && time_tbl[p] < q)
                        p++;
                end else begin
                    while (p > 0 && time_tbl[p] >= q)
                        p--;
                    p++;
                end
                if (p < 1)
                    p = 1;
                if (p > last_slot)
                    p = last_slot;
                res.value = segment_value(q, p - 1, p);
                res.seg   = seg_t'(p);
                cursor    = p;
            end
            pending.push_back(res);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(word_t value, seg_t seg);
            interp_result_t want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected word value %h segment %0d", value, seg));
                return;
            end
            want = pending.pop_front();
            if (value !== want.value)
                report_mismatch($sformatf("interp_value %h, expected %h", value, want.value));
            if (seg !== want.seg)
                report_mismatch($sformatf("segment_end %0d, expected %0d", seg, want.seg));
        endtask
    endclass

    logic  aclk        = 1'b0;
    logic  aresetn     = 1'b0;
    logic  cfg_wr_en   = 1'b0;
    cnt_t  cfg_wr_data = '0;
    logic  s_valid     = 1'b0;
    logic  s_ready;
    logic  s_req_type  = 1'b0;
    idx_t  s_point_index = '0;
    word_t s_point_time  = '0;
    logic signed [WORD_W-1:0] s_point_value = '0;
    word_t s_query_time  = '0;
    logic  m_valid;
    logic  m_ready     = 1'b0;
    logic signed [WORD_W-1:0] m_interp_value;
    seg_t  m_segment_end;

    interp_scoreboard sb = new();

    // Stimulus-side view of the table, used to aim queries
    word_t plan_time[MAX_POINTS];
    int    eff_n       = 2;
    int    last_seg    = 0;
    int    words_sent  = 0;
    int    send_calm   = 0;
    int    recv_calm   = 0;
    int    hold_cycles = 0;
    int    cycle_count = 0;

    breakpoint_linear_interpolator u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_point_index  (s_point_index),
        .s_point_time   (s_point_time),
        .s_point_value  (s_point_value),
        .s_query_time   (s_query_time),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_interp_value (m_interp_value),
        .m_segment_end  (m_segment_end)
    );

    always #6 aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Both handshakes sampled on the same edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_word(req_t'(s_req_type), s_point_index, s_point_time,
                             s_point_value, s_query_time);
            if (m_valid && m_ready)
                sb.check_result(m_interp_value, m_segment_end);
        end
    end

    // Wait before a word: mostly short, at times longer, with calm stretches of none
    function automatic int draw_gap(ref int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0) begin
            calm = $urandom_range(10, 60);
            return 0;
        end
        return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 2);
    endfunction

    function automatic word_t pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'h7FFF_FFFF;
        if (r == 1)
            return 32'h8000_0000;
        if (r < 4)
            return word_t'($urandom_range(0, 2000)) - 32'd1000;
        return $urandom;
    endfunction

    // Query time: clamps, breakpoints and neighbors, nearby and far segments, noise
    function automatic word_t pick_query(int n);
        int    r, i;
        word_t lo, hi;
        r = $urandom_range(0, 99);
        if (r < 4)
            return '0;
        if (r < 8)
            return '1;
        if (r < 16)
            return plan_time[$urandom_range(0, n - 1)];
        if (r < 22) begin
            lo = plan_time[$urandom_range(0, n - 1)];
            return $urandom_range(0, 1) ? lo + 32'd1 : lo - 32'd1;
        end
        if (r < 30)
            return $urandom;
        i = (r < 55) ? last_seg + int'($urandom_range(0, 4)) - 2 : $urandom_range(0, n - 2);
        if (i < 0)
            i = 0;
        if (i > n - 2)
            i = n - 2;
        last_seg = i;
        lo = plan_time[i];
        hi = plan_time[i + 1];
        if (hi > lo)
            return lo + $urandom % (hi - lo);
        return $urandom;
    endfunction

    // Offer one word; returns at the edge where it is taken
    task automatic send_word(req_t req, idx_t idx, word_t t, word_t v, word_t q);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_type    <= req;
        s_point_index <= idx;
        s_point_time  <= t;
        s_point_value <= v;
        s_query_time  <= q;
        if (req == REQ_LOAD)
            plan_time[idx] = t;
        words_sent++;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    task automatic load_point(idx_t idx, word_t t, word_t v);
        send_word(REQ_LOAD, idx, t, v, $urandom);
    endtask

    task automatic query(word_t q);
        send_word(REQ_QUERY, idx_t'($urandom), $urandom, $urandom, q);
    endtask

    // Count register change, only once the block has gone idle
    task automatic write_count(cnt_t c);
        s_valid <= 1'b0;
        // first let the last accepted word be queued by the scoreboard
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LOAD_SETTLE) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= c;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_count(c);
        eff_n = (c < 2) ? 2 : ((c > MAX_POINTS) ? MAX_POINTS : c);
        last_seg = 0;
    endtask

    // Fresh table in slots 0..n-1; mostly rising, sometimes with repeated or out-of-order times
    task automatic build_table(int n);
        word_t t[MAX_POINTS];
        word_t t0, step_max;
        int    style, i, j;
        bit    rising;
        style  = $urandom_range(0, 3);
        rising = ($urandom_range(0, 4) != 0);
        t0 = (style == 3) ? '0 : $urandom_range(0, 32'h7FFF_FFFF);
        step_max = (32'hFFFF_FFFF - t0) / n;
        if (style == 1 && step_max > 3)
            step_max = 3;
        if (style == 2 && step_max > 65536)
            step_max = 65536;
        t[0] = t0;
        for (i = 1; i < n; i++)
            t[i] = t[i - 1] + $urandom_range(1, step_max);
        if (style == 3)
            t[n - 1] = '1;
        if (!rising) begin
            repeat ($urandom_range(1, 3)) begin
                i = $urandom_range(0, n - 1);
                j = $urandom_range(0, n - 1);
                t[i] = $urandom_range(0, 1) ? t[j] : $urandom;
            end
        end
        for (i = 0; i < n; i++)
            load_point(idx_t'(i), t[i], pick_value());
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        int gap;
        @(posedge aclk);
        forever begin
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end
            gap = draw_gap(recv_calm);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    initial begin : stimulus
        cnt_t fixed_counts[10];
        cnt_t count_now;
        int   k, i;

        fixed_counts = '{9'd0, 9'd3, 9'd1, 9'd256, 9'd5,
                         9'd511, 9'd9, 9'd300, 9'd4, 9'd2};
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: two-point table at reset count, extreme times and values
        load_point(8'd0, 32'h0000_1000, 32'h7FFF_FFFF);
        load_point(8'd1, 32'hFFFF_0000, 32'h8000_0000);
        query(32'h0000_0000);               // below first time
        query(32'h0000_1000);               // exactly first time
        query(32'h0000_1001);               // just inside
        query(32'h8000_0800);               // middle, steepest falling slope
        query(32'hFFFE_FFFF);               // just below last time
        query(32'hFFFF_0000);               // exactly last time
        query(32'hFFFF_FFFF);               // top of range
        load_point(8'd255, 32'hFFFF_FFFF, 32'h7FFF_FFFF);  // slot beyond count
        load_point(8'd0, 32'h0000_0000, 32'h8000_0000);
        load_point(8'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        query(32'h0000_0001);
        query(32'h8000_0000);
        query(32'hFFFF_FFFE);
        load_point(8'd1, 32'h0000_0000, 32'h0000_1234);    // equal times, zero span
        query(32'h0000_0000);
        query(32'h0000_0005);

        // Random phases: new count, new table, then queries with the odd reload
        k = 0;
        while (words_sent < TARGET_WORDS) begin
            if (k < 10)
                count_now = fixed_counts[k];
            else if ($urandom_range(0, 3) == 0)
                count_now = $urandom_range(13, 48);
            else
                count_now = $urandom_range(2, 12);
            write_count(count_now);
            build_table(eff_n);
            if (k == 1)
                hold_cycles = HOLD_CYCLES;
            repeat ($urandom_range(60, 140)) begin
                if ($urandom_range(0, 19) == 0) begin
                    i = $urandom_range(0, eff_n - 1);
                    load_point(idx_t'(i), $urandom_range(0, 1) ? plan_time[i] : $urandom,
                               pick_value());
                end else begin
                    query(pick_query(eff_n));
                end
            end
            k++;
        end

        // Drain
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
design/bli_pkg.sv
design/bli_ram.sv
design/bli_ctrl.sv
design/bli_dp.sv
design/breakpoint_linear_interpolator.sv
tb/sv/breakpoint_linear_interpolator_tb.sv
